FILE: sv/dmd_pkg.sv
// Shared types and constants for the delimited message deframer.
`timescale 1ns / 1ps
`default_nettype none
package dmd_pkg;

  // Marker strings; the leftmost character is the oldest byte on the wire
  localparam int START_LEN = 11;
  localparam int END_LEN   = 9;
  localparam logic [8*START_LEN-1:0] START_MARK = {"|MSG_", "START|"};
  localparam logic [8*END_LEN-1:0]   END_MARK   = "|MSG_END|";

  // Holdback fill counter and payload counter
  localparam int FILL_W  = 4;
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 12'd2048;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       overflow;
  } out_item_t;

  // Classification of one in-frame byte
  typedef enum logic [2:0] {
    K_HOLD,      // byte enters holdback, nothing released
    K_PASS,      // oldest held byte released as payload
    K_END,       // end marker complete, empty payload
    K_END_PASS,  // end marker complete, last payload byte released
    K_OVERFLOW   // frame too long, dropped
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage
`default_nettype wire

FILE: sv/dmd_front.sv
// Front end: marker hunting, frame tracking and byte classification.
`timescale 1ns / 1ps
`default_nettype none
module dmd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire dmd_pkg::in_item_t item,
  output dmd_pkg::cmd_t         cmd,
  output logic                  push
);
  import dmd_pkg::*;

  logic [8*START_LEN-1:0] history;
  logic [8*START_LEN-1:0] history_next;
  logic                   in_frame;
  logic                   in_frame_next;
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      fill_next;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_next;
  logic                   release_byte;

  // Classification of the current byte
  always_comb begin
    history_next  = {history[8*START_LEN-9:0], item.data_byte};
    in_frame_next = in_frame;
    fill_next     = fill;
    count_next    = count;
    release_byte  = 1'b0;
    push          = 1'b0;
    cmd.kind      = K_HOLD;
    cmd.data_byte = item.data_byte;
    if (item.flush) begin
      history_next  = '0;
      in_frame_next = 1'b0;
      fill_next     = '0;
      count_next    = '0;
    end else if (!in_frame) begin
      if (history_next == START_MARK) begin
        in_frame_next = 1'b1;
        fill_next     = '0;
        count_next    = '0;
      end
    end else begin
      push         = accept;
      release_byte = (fill == FILL_W'(END_LEN));
      fill_next    = release_byte ? FILL_W'(END_LEN) : fill + FILL_W'(1);
      if (release_byte && count >= MAX_PAYLOAD) begin
        cmd.kind      = K_OVERFLOW;
        in_frame_next = 1'b0;
        fill_next     = '0;
        count_next    = '0;
      end else begin
        count_next = release_byte ? count + COUNT_W'(1) : count;
        // holdback equals the newest END_LEN bytes once it is full
        if (fill_next == FILL_W'(END_LEN) && history_next[8*END_LEN-1:0] == END_MARK) begin
          cmd.kind      = release_byte ? K_END_PASS : K_END;
          in_frame_next = 1'b0;
          fill_next     = '0;
          count_next    = '0;
        end else begin
          cmd.kind = release_byte ? K_PASS : K_HOLD;
        end
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= '0;
      in_frame <= 1'b0;
      fill     <= '0;
      count    <= '0;
    end else if (accept) begin
      history  <= history_next;
      in_frame <= in_frame_next;
      fill     <= fill_next;
      count    <= count_next;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(END_LEN))
    else $error("holdback fill beyond line length");
  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (fill == '0 && count == '0))
    else $error("frame counters not cleared outside a frame");

endmodule
`default_nettype wire

FILE: sv/dmd_cmd_fifo.sv
// Short command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module dmd_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dmd_pkg::cmd_t wr_cmd,
  input  wire logic          pop,
  output dmd_pkg::cmd_head_t head,
  output logic               full
);
  import dmd_pkg::*;

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full       = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("command queue underrun");

endmodule
`default_nettype wire

FILE: sv/dmd_back.sv
// Back end: holdback line, payload release and output register.
`timescale 1ns / 1ps
`default_nettype none
module dmd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dmd_pkg::cmd_head_t head,
  output logic                    pop,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output dmd_pkg::out_item_t      res_item
);
  import dmd_pkg::*;

  logic [8*END_LEN-1:0] holdback;
  logic [7:0]           oldest;
  logic                 emit;
  out_item_t            res_next;

  assign oldest = holdback[8*END_LEN-1 -: 8];

  // Take a command when its result has somewhere to go; a hold command has no result and is always taken
  assign pop  = head.valid && (head.cmd.kind == K_HOLD || !res_valid || !res_stall);
  assign emit = pop && (head.cmd.kind != K_HOLD);

  // Result for the command at the queue head
  always_comb begin
    res_next = '0;
    unique case (head.cmd.kind)
      K_HOLD: res_next = '0;
      K_PASS: begin
        res_next.payload_byte = oldest;
        res_next.byte_valid   = 1'b1;
      end
      K_END: res_next.frame_end = 1'b1;
      K_END_PASS: begin
        res_next.payload_byte = oldest;
        res_next.byte_valid   = 1'b1;
        res_next.frame_end    = 1'b1;
      end
      K_OVERFLOW: res_next.overflow = 1'b1;
      default: res_next = '0;
    endcase
  end

  // Holdback line and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      holdback <= {holdback[8*END_LEN-9:0], head.cmd.data_byte};
    end
    if (emit) begin
      res_item <= res_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  a_overflow_alone: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.overflow) |-> (!res_item.byte_valid && !res_item.frame_end))
    else $error("overflow result carries payload or frame end");
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.byte_valid || res_item.frame_end || res_item.overflow))
    else $error("empty result presented");

endmodule
`default_nettype wire

FILE: sv/delimited_message_deframer_core.sv
// Top level of the delimited message deframer.
// A byte pushed out of holdback passes the command queue, then the output register.
// One stream byte per cycle unless the queue is full; classification is combinational.
// A 4-entry command queue decouples the front end from the output register stall.
// Reset (rst, synchronous): history, frame state, queue and output valid clear.
`timescale 1ns / 1ps
`default_nettype none
module delimited_message_deframer_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               stream_valid,
  output logic                    stream_stall,
  input  wire dmd_pkg::in_item_t  stream_item,
  output logic                    msg_valid,
  input  wire logic               msg_stall,
  output dmd_pkg::out_item_t      msg_item
);
  import dmd_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  logic      full;
  cmd_t      cmd;
  cmd_head_t head;

  assign stream_stall = full;
  assign accept       = stream_valid && !full;

  dmd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (stream_item),
    .cmd    (cmd),
    .push   (push)
  );

  dmd_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (cmd),
    .pop    (pop),
    .head   (head),
    .full   (full)
  );

  dmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (msg_valid),
    .res_stall (msg_stall),
    .res_item  (msg_item)
  );

endmodule
`default_nettype wire

FILE: tb/delimited_message_deframer_checker.sv
// Scoreboard for the deframer: predicts message results from accepted stream bytes and checks them.
`timescale 1ns / 1ps
module delimited_message_deframer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               stream_valid,
  input  logic               stream_stall,
  input  dmd_pkg::in_item_t  stream_item,
  input  logic               msg_valid,
  input  logic               msg_stall,
  input  dmd_pkg::out_item_t msg_item,
  output int                 error_count,
  output int                 pending_count
);
  import dmd_pkg::*;

  // Predicted deframer state
  logic [8*START_LEN-1:0] stream_hist;  // newest byte in the low lane
  logic [8*END_LEN-1:0]   holdback;     // oldest held byte in the top lane
  int                     held;
  logic                   framing;
  int                     released_count;

  out_item_t expected_msgs[$];

  function automatic out_item_t make_msg(logic [7:0] b, logic v, logic fe, logic ov);
    out_item_t m;
    m.payload_byte = b;
    m.byte_valid   = v;
    m.frame_end    = fe;
    m.overflow     = ov;
    return m;
  endfunction

  task automatic close_frame();
    framing        = 1'b0;
    held           = 0;
    released_count = 0;
    holdback       = '0;
  endtask

  // One accepted stream transaction through the predictor
  task automatic deframe_step(input in_item_t it);
    logic       rel;
    logic [7:0] rel_byte;
    if (it.flush) begin
      stream_hist = '0;
      close_frame();
      return;
    end
    stream_hist = {stream_hist[8*START_LEN-9:0], it.data_byte};

    // Hunting: look for the start marker in the last bytes
    if (!framing) begin
      if (stream_hist == START_MARK) begin
        close_frame();
        framing = 1'b1;
      end
      return;
    end

    // In frame: push through holdback, oldest byte falls out once it is full
    rel      = (held >= END_LEN);
    rel_byte = holdback[8*END_LEN-1 -: 8];
    holdback = {holdback[8*END_LEN-9:0], it.data_byte};
    if (!rel) held++;

    if (rel) begin
      if (released_count >= int'(MAX_PAYLOAD)) begin
        close_frame();
        expected_msgs.push_back(make_msg(8'h00, 1'b0, 1'b0, 1'b1));
        return;
      end
      released_count++;
    end

    if (held == END_LEN && holdback == END_MARK) begin
      close_frame();
      expected_msgs.push_back(make_msg(rel ? rel_byte : 8'h00, rel, 1'b1, 1'b0));
      return;
    end

    if (rel) expected_msgs.push_back(make_msg(rel_byte, 1'b1, 1'b0, 1'b0));
  endtask

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // Watch both channels; predict first, then compare the delivered transaction
  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (rst) begin
      stream_hist = '0;
      close_frame();
      expected_msgs.delete();
    end else begin
      if (stream_valid && !stream_stall) deframe_step(stream_item);

      if (msg_valid && !msg_stall) begin
        if (expected_msgs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, msg_item);
        end else begin
          want = expected_msgs.pop_front();
          bad  = 1'b0;
          if (msg_item.payload_byte !== want.payload_byte) begin
            bad = 1'b1;
            $display("%0t: payload_byte expected %h actual %h",
                     $time, want.payload_byte, msg_item.payload_byte);
          end
          if (msg_item.byte_valid !== want.byte_valid) begin
            bad = 1'b1;
            $display("%0t: byte_valid expected %b actual %b",
                     $time, want.byte_valid, msg_item.byte_valid);
          end
          if (msg_item.frame_end !== want.frame_end) begin
            bad = 1'b1;
            $display("%0t: frame_end expected %b actual %b",
                     $time, want.frame_end, msg_item.frame_end);
          end
          if (msg_item.overflow !== want.overflow) begin
            bad = 1'b1;
            $display("%0t: overflow expected %b actual %b",
                     $time, want.overflow, msg_item.overflow);
          end
          if (bad) error_count++;
        end
      end
    end
    pending_count = expected_msgs.size();
  end

endmodule

FILE: tb/delimited_message_deframer_core_test.sv
// Testbench top for the deframer: stream stimulus, receiver stalls and the final verdict.
`timescale 1ns / 1ps
module delimited_message_deframer_core_test;
  import dmd_pkg::*;

  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 10;   // covers the output latency
  localparam int          HOLDOFF_CYCLES = 300;
  localparam int          RANDOM_ITEMS   = 800;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic      clk;
  logic      rst;
  logic      stream_valid;
  logic      stream_stall;
  in_item_t  stream_item;
  logic      msg_valid;
  logic      msg_stall;
  out_item_t msg_item;

  int          error_count;
  int          pending_count;
  int          send_idle_pct  = 20;
  int          recv_stall_pct = 20;
  bit          holdoff_req    = 1'b0;
  int          holdoff_left   = 0;
  int          sent_items     = 0;
  int unsigned cycle_count    = 0;

  delimited_message_deframer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_item  (stream_item),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg_item     (msg_item)
  );

  delimited_message_deframer_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .stream_valid  (stream_valid),
    .stream_stall  (stream_stall),
    .stream_item   (stream_item),
    .msg_valid     (msg_valid),
    .msg_stall     (msg_stall),
    .msg_item      (msg_item),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off when requested
  initial begin
    msg_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        msg_stall <= 1'b1;
      end else begin
        msg_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      stream_valid <= 1'b0;
      @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_item  <= it;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.flush     = 1'b0;
    send_item(it);
  endtask

  task automatic send_flush();
    in_item_t it;
    it.data_byte = 8'($urandom_range(255));
    it.flush     = 1'b1;
    send_item(it);
  endtask

  // Bytes first..n-1 of a marker, oldest character first
  task automatic send_mark(input logic [8*START_LEN-1:0] mark, input int len,
                           input int first, input int n);
    for (int i = first; i < n; i++) send_byte(mark[8*(len-1-i) +: 8]);
  endtask

  // Random byte, biased toward marker characters to provoke near misses
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r < 2) return START_MARK[8*$urandom_range(START_LEN-1) +: 8];
    if (r < 4) return END_MARK[8*$urandom_range(END_LEN-1) +: 8];
    return 8'($urandom_range(255));
  endfunction

  function automatic int payload_len();
    if ($urandom_range(7) == 0) return 0;
    return $urandom_range(1, 24);
  endfunction

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++) send_byte(pick_byte());
  endtask

  // End marker cut short by a wrong character
  task automatic send_broken_end();
    int         k;
    logic [7:0] b;
    k = $urandom_range(1, END_LEN-1);
    send_mark(END_MARK, END_LEN, 0, k);
    b = pick_byte();
    if (b == END_MARK[8*(END_LEN-1-k) +: 8]) b = ~b;
    send_byte(b);
  endtask

  task automatic send_frame(input int n);
    send_mark(START_MARK, START_LEN, 0, START_LEN);
    send_payload(n);
    send_mark(END_MARK, END_LEN, 0, END_LEN);
  endtask

  // Mostly well-formed frames with random content; the rest noise and broken frames
  task automatic random_sequence();
    int         pick;
    int         k;
    logic [7:0] b;
    pick = $urandom_range(99);
    send_payload($urandom_range(3));
    if (pick < 45) begin
      send_frame(payload_len());
    end else if (pick < 55) begin
      // start marker inside the payload stays payload
      send_mark(START_MARK, START_LEN, 0, START_LEN);
      send_payload(payload_len());
      send_mark(START_MARK, START_LEN, 0, START_LEN);
      send_payload(payload_len());
      send_mark(END_MARK, END_LEN, 0, END_LEN);
    end else if (pick < 65) begin
      send_mark(START_MARK, START_LEN, 0, START_LEN);
      send_payload(payload_len());
      send_broken_end();
      send_payload(payload_len());
      send_mark(END_MARK, END_LEN, 0, END_LEN);
    end else if (pick < 75) begin
      // next start marker shares its leading bar with the end marker
      send_frame(payload_len());
      send_mark(START_MARK, START_LEN, 1, START_LEN);
      send_payload(payload_len());
      send_mark(END_MARK, END_LEN, 0, END_LEN);
    end else if (pick < 83) begin
      // flush abandons an open frame
      send_mark(START_MARK, START_LEN, 0, START_LEN);
      send_payload(payload_len());
      if ($urandom_range(1)) send_mark(END_MARK, END_LEN, 0, $urandom_range(1, END_LEN-1));
      send_flush();
    end else if (pick < 91) begin
      // start marker cut short
      k = $urandom_range(1, START_LEN-1);
      send_mark(START_MARK, START_LEN, 0, k);
      b = pick_byte();
      if (b == START_MARK[8*(START_LEN-1-k) +: 8]) b = ~b;
      send_byte(b);
      send_payload(payload_len());
    end else begin
      send_payload($urandom_range(4, 20));
      if ($urandom_range(1)) send_flush();
    end
  endtask

  // Stop offering and let every expected result come out
  task automatic wait_drained();
    stream_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst          <= 1'b1;
    stream_valid <= 1'b0;
    stream_item  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: byte extremes as noise, a flush, then an empty frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_flush();
    send_frame(0);
    wait_drained();

    // Random with idling on both sides
    while (sent_items < RANDOM_ITEMS / 3) random_sequence();
    wait_drained();

    // Long stretch with no idling at all
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sent_items < 2 * RANDOM_ITEMS / 3) random_sequence();

    // Receiver holds off while frames keep coming, so the block backs up
    holdoff_req = 1'b1;
    for (int i = 0; i < 6; i++) send_frame($urandom_range(10, 24));
    wait_drained();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    while (sent_items < RANDOM_ITEMS) random_sequence();

    // Payload length at the limit, one past it with the end marker, and a runaway frame
    send_frame(int'(MAX_PAYLOAD));
    send_frame(int'(MAX_PAYLOAD) + 1);
    send_mark(START_MARK, START_LEN, 0, START_LEN);
    send_payload(int'(MAX_PAYLOAD) + 12);
    send_flush();
    send_frame(payload_len());
    wait_drained();

    if (error_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
